@@ rtl/core/polar_gaussian_sampler_macros.svh @@
// Assertion macros used by the sampler's back end.
`ifndef POLAR_GAUSSIAN_SAMPLER_MACROS_SVH
`define POLAR_GAUSSIAN_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is active.
`define PGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ rtl/core/pgs_pkg.sv @@
`default_nettype none
package pgs_pkg;

	// Fixed field widths and queue depth of the sampler.
	localparam int UNIFORM_BITS  = 16;
	localparam int FRACTION_BITS = 16;
	localparam int LOG_BITS      = 24;
	localparam int DIFF_W        = UNIFORM_BITS + 1;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

	// Low part of round(2 ln2 * 2^32); the high part is exactly 2^32.
	localparam logic [30:0] TWO_LN2_LOW = 31'd1659121648;

	// Configuration register indexes.
	localparam logic [7:0] REG_MEAN  = 8'd0;
	localparam logic [7:0] REG_SCALE = 8'd1;

	// One accepted pair: centered uniforms and s in Q0.32.
	typedef struct packed {
		logic signed [DIFF_W-1:0] d1;
		logic signed [DIFF_W-1:0] d2;
		logic [31:0]              s32;
	} pair_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		B_IDLE,
		B_LOG,
		B_NLOG,
		B_NLSUM,
		B_DIV,
		B_ROOTPREP,
		B_SQRT,
		B_MAG,
		B_SCALE,
		B_SUM,
		B_OUT
	} back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/pgs_front.sv @@
`default_nettype none
module pgs_front (
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [15:0]                uniform_a,
	input  wire logic [15:0]                uniform_b,
	input  wire pgs_pkg::fifo_stat_t        stat,
	output logic                            push,
	output pgs_pkg::pair_t                  pair
);

	logic signed [pgs_pkg::DIFF_W-1:0] d1, d2;
	logic signed [2*pgs_pkg::DIFF_W-1:0] sq1, sq2;
	logic [31:0] sum;
	logic keep;

	// Center the uniforms and form the squared radius.
	always_comb begin
		d1 = $signed({1'b0, uniform_a}) - $signed(17'd32768);
		d2 = $signed({1'b0, uniform_b}) - $signed(17'd32768);
		sq1 = d1 * d1;
		sq2 = d2 * d2;
		sum = sq1[31:0] + sq2[31:0];
		keep = (sum != 32'd0) && (sum < 32'h4000_0000);
		pair.d1 = d1;
		pair.d2 = d2;
		pair.s32 = {sum[29:0], 2'b00};
	end

	// Rejected pairs are taken and dropped; kept pairs go to the queue.
	assign in_ready = !stat.full;
	assign push = in_valid && in_ready && keep;

endmodule
`default_nettype wire

@@ rtl/core/pgs_fifo.sv @@
`default_nettype none
module pgs_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire pgs_pkg::pair_t      wr_pair,
	input  wire logic                pop,
	output pgs_pkg::pair_t           rd_pair,
	output pgs_pkg::fifo_stat_t      stat
);

	pgs_pkg::pair_t mem_q [pgs_pkg::FIFO_DEPTH];
	logic [pgs_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
	logic [pgs_pkg::FIFO_AW:0]   count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_pair;
	end

	assign rd_pair = mem_q[rptr_q];
	assign stat.full = (count_q == (pgs_pkg::FIFO_AW+1)'(pgs_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule
`default_nettype wire

@@ rtl/core/pgs_back.sv @@
`default_nettype none
`include "polar_gaussian_sampler_macros.svh"
module pgs_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pgs_pkg::fifo_stat_t stat,
	input  wire pgs_pkg::pair_t      head,
	output logic                     pop,
	input  wire logic signed [23:0]  mean_value,
	input  wire logic [23:0]         deviation_scale,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       sample,
	output logic                     last
);

	pgs_pkg::back_state_t state_q, state_d;

	logic [5:0]  cnt_q;
	logic [31:0] m_q;
	logic [23:0] frac_q;
	logic [5:0]  lgint_q;
	logic signed [pgs_pkg::DIFF_W-1:0] d1_q, d2_q;
	logic [31:0] s_q;
	logic [29:0] lg_q;
	logic [60:0] lgk_q;
	logic [61:0] num_q, quo_q;
	logic [31:0] rem_q;
	logic [63:0] x_q, r_q, b_q;
	logic        big_q, sel_q, neg_q;
	logic [51:0] mag_q;
	logic [60:0] prod_q;
	logic signed [31:0] sample_q;
	logic        last_q;

	logic [4:0]  p;
	logic [63:0] msq;
	logic [32:0] trial;
	logic [63:0] rb;
	logic [35:0] f;
	logic signed [pgs_pkg::DIFF_W-1:0] dsel, dabs;
	logic [44:0] ymag_raw;
	logic [40:0] ymag;
	logic signed [42:0] y;
	logic signed [31:0] y_sat;
	logic step_done;

	// Leading one of s, the squared mantissa, the divide and root trials and the output scaling.
	always_comb begin
		p = '0;
		for (int i = 1; i < 32; i++) begin
			if (head.s32[i]) p = 5'(i);
		end
		msq = m_q * m_q;
		trial = {rem_q, num_q[61]};
		rb = r_q + b_q;
		f = big_q ? {r_q[31:0], 4'b0000} : {4'b0000, r_q[31:0]};
		dsel = sel_q ? d2_q : d1_q;
		dabs = (dsel < 0) ? -dsel : dsel;
		ymag_raw = prod_q[60:16];
		ymag = (ymag_raw > 45'h100_0000_0000) ? 41'h100_0000_0000 : ymag_raw[40:0];
		y = (neg_q ? -$signed({2'b00, ymag}) : $signed({2'b00, ymag}))
			+ 43'(mean_value);
		if (y > 43'sd2147483647) y_sat = 32'sh7FFF_FFFF;
		else if (y < -43'sd2147483648) y_sat = 32'sh8000_0000;
		else y_sat = y[31:0];
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		step_done = 1'b0;
		case (state_q)
			pgs_pkg::B_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					state_d = pgs_pkg::B_LOG;
				end
			end
			pgs_pkg::B_LOG: begin
				if (cnt_q == 6'(pgs_pkg::LOG_BITS - 1)) state_d = pgs_pkg::B_NLOG;
			end
			pgs_pkg::B_NLOG: state_d = pgs_pkg::B_NLSUM;
			pgs_pkg::B_NLSUM: state_d = pgs_pkg::B_DIV;
			pgs_pkg::B_DIV: begin
				if (cnt_q == 6'd61) state_d = pgs_pkg::B_ROOTPREP;
			end
			pgs_pkg::B_ROOTPREP: state_d = pgs_pkg::B_SQRT;
			pgs_pkg::B_SQRT: begin
				if (cnt_q == 6'd31) state_d = pgs_pkg::B_MAG;
			end
			pgs_pkg::B_MAG: state_d = pgs_pkg::B_SCALE;
			pgs_pkg::B_SCALE: state_d = pgs_pkg::B_SUM;
			pgs_pkg::B_SUM: state_d = pgs_pkg::B_OUT;
			pgs_pkg::B_OUT: begin
				if (out_ready) begin
					step_done = 1'b1;
					state_d = sel_q ? pgs_pkg::B_IDLE : pgs_pkg::B_MAG;
				end
			end
			default: state_d = pgs_pkg::B_IDLE;
		endcase
	end

	// State register and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgs_pkg::B_IDLE;
			cnt_q <= '0;
			sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (pop) sel_q <= 1'b0;
			else if (step_done) sel_q <= 1'b1;
		end
	end

	// Datapath: log by squaring, scaling by 2 ln2, divide, root, then the two samples.
	always_ff @(posedge clk) begin
		case (state_q)
			pgs_pkg::B_IDLE: begin
				d1_q <= head.d1;
				d2_q <= head.d2;
				s_q <= head.s32;
				m_q <= head.s32 << (5'd31 - p);
				frac_q <= '0;
				lgint_q <= 6'd32 - {1'b0, p};
			end
			pgs_pkg::B_LOG: begin
				if (msq[63]) begin
					m_q <= msq[63:32];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					m_q <= msq[62:31];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			pgs_pkg::B_NLOG: begin
				lg_q <= {lgint_q, 24'b0} - {6'b0, frac_q};
				lgk_q <= ({31'b0, ({lgint_q, 24'b0} - {6'b0, frac_q})})
					* {30'b0, pgs_pkg::TWO_LN2_LOW};
			end
			pgs_pkg::B_NLSUM: begin
				num_q <= {lg_q + {1'b0, lgk_q[60:32]}, 32'b0};
				rem_q <= '0;
				quo_q <= '0;
			end
			pgs_pkg::B_DIV: begin
				num_q <= {num_q[60:0], 1'b0};
				if (trial >= {1'b0, s_q}) begin
					rem_q <= 32'(trial - {1'b0, s_q});
					quo_q <= {quo_q[60:0], 1'b1};
				end else begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[60:0], 1'b0};
				end
			end
			pgs_pkg::B_ROOTPREP: begin
				big_q <= |quo_q[61:56];
				x_q <= (|quo_q[61:56]) ? {2'b00, quo_q} : {quo_q[55:0], 8'b0};
				r_q <= '0;
				b_q <= 64'h4000_0000_0000_0000;
			end
			pgs_pkg::B_SQRT: begin
				if (x_q >= rb) begin
					x_q <= x_q - rb;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
			pgs_pkg::B_MAG: begin
				neg_q <= (dsel < 0);
				mag_q <= {36'b0, dabs[15:0]} * {16'b0, f};
			end
			pgs_pkg::B_SCALE: begin
				prod_q <= {24'b0, mag_q[51:15]} * {37'b0, deviation_scale};
			end
			pgs_pkg::B_SUM: begin
				sample_q <= y_sat;
				last_q <= sel_q;
			end
			default: ;
		endcase
	end

	assign out_valid = (state_q == pgs_pkg::B_OUT);
	assign sample = sample_q;
	assign last = last_q;

	`PGS_ASSERT_IMP(a_mant_norm, clk, arst_n, state_q == pgs_pkg::B_LOG, m_q[31])
	`PGS_ASSERT_IMP(a_pop_idle, clk, arst_n, pop, state_q == pgs_pkg::B_IDLE && !stat.empty)
	`PGS_ASSERT_NXT(a_last_idle, clk, arst_n, out_valid && out_ready && sel_q,
		state_q == pgs_pkg::B_IDLE)
	`PGS_ASSERT_NXT(a_first_next, clk, arst_n, out_valid && out_ready && !sel_q,
		state_q == pgs_pkg::B_MAG && sel_q)

endmodule
`default_nettype wire

@@ rtl/core/polar_gaussian_sampler.sv @@
`default_nettype none
// Marsaglia polar normal sampler. Each input word holds two Q0.16 uniforms; pairs
// outside the unit circle or at its center are dropped silently, every other pair
// yields two Q16.16 words, scaled by deviation_scale, offset by mean_value and
// saturated, the second with last set. A four-entry queue sits between the input
// side, which takes one word per cycle while the queue has room, and the back end,
// a single shared sequencer that finishes one kept pair, including any output
// stall, before it takes the next: log by squaring, bit-serial division and
// bit-serial square root dominate its time. Configuration writes take effect
// at once and are always ready.
module polar_gaussian_sampler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        uniform_a,
	input  wire logic [15:0]        uniform_b,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      sample,
	output logic                    last
);

	logic signed [23:0] mean_value_q;
	logic [23:0]        deviation_scale_q;
	pgs_pkg::fifo_stat_t stat;
	pgs_pkg::pair_t     wr_pair, head;
	logic push, pop;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_value_q <= '0;
			deviation_scale_q <= 24'd65536;
		end else if (cfg_valid) begin
			if (cfg_index == pgs_pkg::REG_MEAN) mean_value_q <= cfg_data;
			else if (cfg_index == pgs_pkg::REG_SCALE) deviation_scale_q <= cfg_data;
		end
	end

	pgs_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.uniform_a(uniform_a),
		.uniform_b(uniform_b),
		.stat     (stat),
		.push     (push),
		.pair     (wr_pair)
	);

	pgs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_pair(wr_pair),
		.pop    (pop),
		.rd_pair(head),
		.stat   (stat)
	);

	pgs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.stat           (stat),
		.head           (head),
		.pop            (pop),
		.mean_value     (mean_value_q),
		.deviation_scale(deviation_scale_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample         (sample),
		.last           (last)
	);

endmodule
`default_nettype wire

@@ tb/tb_polar_gaussian_sampler.sv @@
`default_nettype none
module tb_polar_gaussian_sampler;

	// Register indexes that the block does not decode; writes to them are ignored.
	localparam logic [7:0] REG_SPARE = 8'd2;
	localparam logic [7:0] REG_TOP   = 8'hFF;
	localparam longint unsigned TWO_LN2_Q32 = 64'd5954088944;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int SQUEEZE_CYCLES = 600;

	typedef struct {
		logic [15:0] ua;
		logic [15:0] ub;
	} uniform_word_t;

	typedef struct {
		logic signed [31:0] smp;
		logic               lst;
	} gauss_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        uniform_a = '0;
	logic [15:0]        uniform_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] sample;
	logic               last;

	// Shadow copies of the configuration registers.
	longint          mean_shadow = 0;
	longint unsigned scale_shadow = 65536;

	uniform_word_t pending_words[$];
	gauss_word_t   expected_samples[$];
	int            mismatches = 0;
	int            in_gap = 0;
	int            out_gap = 0;
	int            hold_left = 0;
	bit            idle_en = 1'b1;
	bit            squeeze_req = 1'b0;
	int            stall_count = 0;

	polar_gaussian_sampler u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .uniform_a(uniform_a), .uniform_b(uniform_b),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample), .last(last)
	);

	always #5 clk = ~clk;

	// Integer square root, floor.
	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Polar gain sqrt(-2 ln s / s) in Q.16, from the exact sum of squares.
	function automatic longint unsigned polar_gain(longint unsigned sum);
		longint unsigned s_q32, mant, frac, neg_log2, neg_ln2x, ratio;
		int lead;
		s_q32 = (sum << 2) & 64'hFFFF_FFFF;
		if (s_q32 == 0) s_q32 = 1;
		lead = 31;
		while (lead > 0 && s_q32[lead] == 1'b0) lead--;
		mant = s_q32 << (31 - lead);
		frac = 0;
		// Fraction bits of log2 by repeated squaring.
		for (int i = 0; i < pgs_pkg::LOG_BITS; i++) begin
			mant = (mant * mant) >> 31;
			frac = frac << 1;
			if (mant >= (64'd1 << 32)) begin
				mant = mant >> 1;
				frac = frac | 64'd1;
			end
		end
		neg_log2 = (longint'(32 - lead) << pgs_pkg::LOG_BITS) - frac;
		neg_ln2x = (neg_log2 * TWO_LN2_Q32) >> 32;
		ratio = (neg_ln2x << 32) / s_q32;
		if (ratio < (64'd1 << 56)) return int_sqrt(ratio << 8);
		return int_sqrt(ratio) << 4;
	endfunction

	// One scaled, offset and saturated normal sample.
	function automatic logic signed [31:0] gauss_value(longint d, longint unsigned gain);
		longint unsigned mag, z, ymag;
		longint y;
		bit neg;
		neg = d < 0;
		mag = longint'(neg ? -d : d) * gain;
		z = mag >> 15;
		if (z > (64'd1 << 38)) z = 64'd1 << 38;
		ymag = (z * scale_shadow) >> pgs_pkg::FRACTION_BITS;
		if (ymag > (64'd1 << 40)) ymag = 64'd1 << 40;
		y = neg ? -longint'(ymag) : longint'(ymag);
		y = y + mean_shadow;
		if (y > 64'sd2147483647) y = 64'sd2147483647;
		if (y < -64'sd2147483648) y = -64'sd2147483648;
		return y[31:0];
	endfunction

	function automatic bit pair_in_circle(logic [15:0] ua, logic [15:0] ub);
		longint d1, d2, sum;
		d1 = longint'(ua) - 32768;
		d2 = longint'(ub) - 32768;
		sum = d1 * d1 + d2 * d2;
		return sum != 0 && sum < (64'sd1 << 30);
	endfunction

	// Queue the two expected samples of an accepted pair, if it is kept.
	task automatic predict_pair(logic [15:0] ua, logic [15:0] ub);
		longint d1, d2;
		longint unsigned gain;
		gauss_word_t w;
		if (pair_in_circle(ua, ub)) begin
			d1 = longint'(ua) - 32768;
			d2 = longint'(ub) - 32768;
			gain = polar_gain(longint'(d1 * d1 + d2 * d2));
			w.smp = gauss_value(d1, gain);
			w.lst = 1'b0;
			expected_samples = {expected_samples, w};
			w.smp = gauss_value(d2, gain);
			w.lst = 1'b1;
			expected_samples = {expected_samples, w};
		end
	endtask

	// Input driver: feeds pending words with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		uniform_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) predict_pair(uniform_a, uniform_b);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					uniform_a <= w.ua;
					uniform_b <= w.ub;
					if (idle_en && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 14);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each word and drives ready with stalls.
	always @(posedge clk or negedge arst_n) begin
		gauss_word_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: sample=%0d last=%0b", sample, last);
				end else begin
					w = expected_samples.pop_front();
					if (sample !== w.smp || last !== w.lst) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: sample exp %0d got %0d, last exp %0b got %0b",
								w.smp, sample, w.lst, last);
					end
				end
			end
			if (squeeze_req && hold_left == 0) begin
				squeeze_req = 1'b0;
				hold_left = SQUEEZE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_en && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 14);
			end
		end
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [23:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == pgs_pkg::REG_MEAN) mean_shadow = longint'($signed(value));
		else if (idx == pgs_pkg::REG_SCALE) scale_shadow = longint'(value);
	endtask

	task automatic add_word(logic [15:0] ua, logic [15:0] ub);
		uniform_word_t w;
		w.ua = ua;
		w.ub = ub;
		pending_words = {pending_words, w};
	endtask

	// Random pairs, mostly inside the unit circle; only kept pairs are counted.
	task automatic add_random(int kept_target);
		int kept;
		int pick;
		logic [15:0] ua, ub;
		kept = 0;
		while (kept < kept_target) begin
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				ua = 16'($urandom);
				ub = 16'($urandom);
			end else if (pick < 5) begin
				ua = 16'(32'd32768 + $urandom_range(0, 64) - 32'd32);
				ub = 16'(32'd32768 + $urandom_range(0, 64) - 32'd32);
			end else begin
				do begin
					ua = 16'($urandom);
					ub = 16'($urandom);
				end while (!pair_in_circle(ua, ub));
			end
			add_word(ua, ub);
			if (pair_in_circle(ua, ub)) kept++;
		end
	endtask

	// Wait until every word is sent and every sample has come back.
	task automatic drain();
		do @(negedge clk);
		while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at reset settings: center, edges, boundary of the circle.
		add_word(16'd32768, 16'd32768);
		add_word(16'd32769, 16'd32768);
		add_word(16'd32768, 16'd32767);
		add_word(16'd0, 16'd0);
		add_word(16'd65535, 16'd65535);
		add_word(16'd0, 16'd32768);
		add_word(16'd32768, 16'd0);
		add_word(16'd1, 16'd32768);
		add_word(16'd65535, 16'd32768);
		add_word(16'd32768, 16'd65535);
		add_word(16'd32768, 16'd1);
		add_word(16'd9598, 16'd9598);
		add_word(16'd9597, 16'd9597);
		add_word(16'd55938, 16'd9598);
		add_word(16'd21845, 16'd43690);
		add_word(16'd32767, 16'd32769);
		add_random(300);
		drain();

		// Extremes: largest mean and scale.
		write_reg(pgs_pkg::REG_MEAN, 24'h7FFFFF);
		write_reg(pgs_pkg::REG_SCALE, 24'hFFFFFF);
		add_word(16'd32769, 16'd32768);
		add_word(16'd1, 16'd32768);
		add_word(16'd32768, 16'd32767);
		add_random(300);
		drain();

		// Most negative mean, zero scale, and a long receiver hold-off.
		write_reg(pgs_pkg::REG_MEAN, 24'h800000);
		write_reg(pgs_pkg::REG_SCALE, 24'h000000);
		write_reg(REG_SPARE, 24'h123456);
		squeeze_req = 1'b1;
		add_random(250);
		drain();

		// Random settings, with an ignored write in between.
		write_reg(pgs_pkg::REG_MEAN, 24'($urandom));
		write_reg(pgs_pkg::REG_SCALE, 24'($urandom_range(0, 24'h3FFFFF)));
		write_reg(REG_TOP, 24'hFFFFFF);
		add_random(200);
		drain();
		write_reg(pgs_pkg::REG_MEAN, 24'($urandom));
		write_reg(pgs_pkg::REG_SCALE, 24'($urandom));
		add_random(200);
		drain();

		// Back to unit settings, no idling on either side.
		write_reg(pgs_pkg::REG_MEAN, 24'h000000);
		write_reg(pgs_pkg::REG_SCALE, 24'h010000);
		idle_en = 1'b0;
		add_random(300);
		drain();

		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/pgs_pkg.sv
rtl/core/pgs_front.sv
rtl/core/pgs_fifo.sv
rtl/core/pgs_back.sv
rtl/core/polar_gaussian_sampler.sv
tb/tb_polar_gaussian_sampler.sv
